FILE: src/vlcp_pkg.sv
// Shared types and constants of the variable-length code packer.
`default_nettype none

package vlcp_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_CODE_BITS = 16;
  localparam int LEN_W         = 5;
  localparam int FILL_W        = 5;
  localparam int TOTAL_W       = 6;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic                     MODE_APPEND  = 1'b0;
  localparam logic                     MODE_FINISH  = 1'b1;
  localparam logic [MAX_CODE_BITS-1:0] FRAME_MARKER = 16'hFFFF;
  localparam logic [LEN_W-1:0]         MARKER_LEN   = 5'd16;
  localparam logic [WORD_BITS-1:0]     START_WORD   = {FRAME_MARKER, 16'd0};
  localparam logic [FILL_W-1:0]        START_FILL   = 5'd16;

  typedef struct packed {
    logic                     mode;
    logic [MAX_CODE_BITS-1:0] code;
    logic                     two_bit_min;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic                     finish;
    logic [MAX_CODE_BITS-1:0] bits;
    logic [LEN_W-1:0]         len;
  } q_entry_t;

endpackage

`default_nettype wire

FILE: src/vlcp_front.sv
// Front end: turns an input item into a queue entry with its bit length.
`default_nettype none

module vlcp_front (
  input  vlcp_pkg::in_item_t in_item,
  output vlcp_pkg::q_entry_t entry
);

  function automatic logic [vlcp_pkg::LEN_W-1:0] code_len(
    input logic [vlcp_pkg::MAX_CODE_BITS-1:0] value,
    input logic                               two_min
  );
    logic [vlcp_pkg::LEN_W-1:0] n;
    n = 5'd1;
    for (int i = 1; i < vlcp_pkg::MAX_CODE_BITS; i++) begin
      if (value[i]) n = 5'(i + 1);
    end
    // with two_min set, codes 0 and 1 widen to two bits
    if (two_min && (value[vlcp_pkg::MAX_CODE_BITS-1:1] == '0)) n = 5'd2;
    return n;
  endfunction

  always_comb begin
    if (in_item.mode == vlcp_pkg::MODE_FINISH) begin
      entry.finish = 1'b1;
      entry.bits   = vlcp_pkg::FRAME_MARKER;
      entry.len    = vlcp_pkg::MARKER_LEN;
    end else begin
      entry.finish = 1'b0;
      entry.bits   = in_item.code;
      entry.len    = code_len(in_item.code, in_item.two_bit_min);
    end
  end

endmodule

`default_nettype wire

FILE: src/vlcp_queue.sv
// Small FIFO between the front end and the packing back end.
`default_nettype none

module vlcp_queue #(
  parameter int DEPTH = vlcp_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  vlcp_pkg::q_entry_t push_data,
  output logic               full,
  input  wire                pop,
  output vlcp_pkg::q_entry_t pop_data,
  output logic               empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vlcp_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue popped while empty");

endmodule

`default_nettype wire

FILE: src/vlcp_back.sv
// Back end: packs queued codes into words and drives the output register.
`default_nettype none

module vlcp_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  vlcp_pkg::q_entry_t  entry,
  output logic                q_pop,
  output logic                out_valid,
  output vlcp_pkg::out_item_t out_data,
  input  wire                 out_stall
);

  logic [vlcp_pkg::WORD_BITS-1:0] pending_r, pending_nxt;
  logic [vlcp_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic                           second_r, second_nxt;
  logic [vlcp_pkg::WORD_BITS-1:0] second_word_r, second_word_nxt;
  logic                           out_valid_r, out_valid_nxt;
  vlcp_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                           load_en;
  logic [vlcp_pkg::TOTAL_W-1:0]   total;
  logic [47:0]                    shifted;
  logic [47:0]                    acc;
  logic                           word_full;
  logic [vlcp_pkg::WORD_BITS-1:0] hi_word;
  logic [vlcp_pkg::WORD_BITS-1:0] lo_word;
  logic [vlcp_pkg::FILL_W-1:0]    rem;

  assign load_en   = !out_valid_r || !out_stall;
  assign total     = {1'b0, fill_r} + {1'b0, entry.len};
  assign shifted   = {32'd0, entry.bits} << (6'd48 - total);
  assign acc       = {pending_r, 16'd0} | shifted;
  assign word_full = total[5];
  assign hi_word   = acc[47:16];
  assign lo_word   = {acc[15:0], 16'd0};
  assign rem       = total[4:0];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pending_nxt     = pending_r;
    fill_nxt        = fill_r;
    second_nxt      = second_r;
    second_word_nxt = second_word_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    q_pop           = 1'b0;
    if (load_en) begin
      out_valid_nxt = 1'b0;
      if (second_r) begin
        // drain the padded tail word of a finish
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{word: second_word_r, last_of_frame: 1'b1};
        second_nxt    = 1'b0;
      end else if (q_valid) begin
        q_pop = 1'b1;
        if (!entry.finish) begin
          if (word_full) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{word: hi_word, last_of_frame: 1'b0};
            pending_nxt   = lo_word;
          end else begin
            pending_nxt = hi_word;
          end
          fill_nxt = rem;
        end else begin
          pending_nxt   = vlcp_pkg::START_WORD;
          fill_nxt      = vlcp_pkg::START_FILL;
          out_valid_nxt = 1'b1;
          if (word_full) begin
            out_data_nxt = '{word: hi_word, last_of_frame: (rem == '0)};
            if (rem != '0) begin
              second_nxt      = 1'b1;
              second_word_nxt = lo_word;
            end
          end else begin
            out_data_nxt = '{word: hi_word, last_of_frame: 1'b1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= vlcp_pkg::START_WORD;
      fill_r      <= vlcp_pkg::START_FILL;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      fill_r      <= fill_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    second_word_r <= second_word_nxt;
    out_data_r    <= out_data_nxt;
  end

  a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r << fill_r) == '0)
    else $error("pending word has bits below fill position");

  a_hold_on_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !(second_r && q_pop))
    else $error("queue popped while tail word waits");

  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (second_r && load_en) |=> (out_valid_r && out_data_r.last_of_frame))
    else $error("tail word not marked last");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("output word changed under stall");

endmodule

`default_nettype wire

FILE: src/variable_length_code_packer_top.sv
// Top level of the MSB-first variable-length code packer.
//
//   channel | ports                         | moves
//   --------+-------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data   | one code or finish per word
//   output  | out_valid, out_stall, out_data| one packed 32-bit word
//
// Codes flow at one per cycle while out_stall is low and no tail word waits.
// A finish that spills past a word yields two output words; the back end
// holds the queue for the tail word. Items pass queue, then output register.
// Reset loads the start marker (fill 16) and empties queue and output.
// in_stall rises when the queue is full: under output backpressure, or after
// several finish tail words at full input rate.
`default_nettype none

module variable_length_code_packer_top #(
  parameter int QUEUE_DEPTH = vlcp_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  vlcp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output vlcp_pkg::out_item_t out_data
);

  vlcp_pkg::q_entry_t front_entry;
  vlcp_pkg::q_entry_t back_entry;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic               q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  vlcp_front u_front (
    .in_item (in_data),
    .entry   (front_entry)
  );

  vlcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (back_entry),
    .empty     (q_empty)
  );

  vlcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .entry     (back_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

FILE: tb/vlcp_word_checker.sv
// Scoreboard that predicts and checks the packed words of the code packer.
`default_nettype none

module vlcp_word_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  vlcp_pkg::in_item_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  vlcp_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  words_pending
);

  logic [vlcp_pkg::WORD_BITS-1:0] pend_word;
  int                             pend_fill;
  vlcp_pkg::out_item_t            expected_words[$];

  initial begin
    fail_count    = 0;
    words_pending = 0;
    pend_word     = vlcp_pkg::START_WORD;
    pend_fill     = int'(vlcp_pkg::START_FILL);
  end

  function automatic int code_width(input logic [vlcp_pkg::MAX_CODE_BITS-1:0] value,
                                    input logic two_min);
    int n;
    n = 1;
    for (int i = 1; i < vlcp_pkg::MAX_CODE_BITS; i++) begin
      if (value[i]) n = i + 1;
    end
    if (two_min && value <= 16'd1) n = 2;
    return n;
  endfunction

  // Append len bits below the filled part; return the word if it completes.
  task automatic shift_in(input logic [vlcp_pkg::MAX_CODE_BITS-1:0] value,
                          input int len, output logic filled,
                          output logic [vlcp_pkg::WORD_BITS-1:0] done_word);
    logic [2*vlcp_pkg::WORD_BITS-1:0] acc;
    logic [2*vlcp_pkg::WORD_BITS-1:0] wide;
    int                               total;
    total = pend_fill + len;
    wide  = {{(2*vlcp_pkg::WORD_BITS-vlcp_pkg::MAX_CODE_BITS){1'b0}}, value};
    acc   = {pend_word, {vlcp_pkg::WORD_BITS{1'b0}}} |
            (wide << (2 * vlcp_pkg::WORD_BITS - total));
    filled = (total >= vlcp_pkg::WORD_BITS);
    if (filled) begin
      done_word = acc[2*vlcp_pkg::WORD_BITS-1:vlcp_pkg::WORD_BITS];
      pend_word = acc[vlcp_pkg::WORD_BITS-1:0];
      pend_fill = total - vlcp_pkg::WORD_BITS;
    end else begin
      done_word = '0;
      pend_word = acc[2*vlcp_pkg::WORD_BITS-1:vlcp_pkg::WORD_BITS];
      pend_fill = total;
    end
  endtask

  task automatic predict_words(input vlcp_pkg::in_item_t it);
    logic                           filled;
    logic [vlcp_pkg::WORD_BITS-1:0] w;
    vlcp_pkg::out_item_t            r;
    if (it.mode == vlcp_pkg::MODE_APPEND) begin
      shift_in(it.code, code_width(it.code, it.two_bit_min), filled, w);
      if (filled) begin
        r.word          = w;
        r.last_of_frame = 1'b0;
        expected_words.push_back(r);
      end
    end else begin
      shift_in(vlcp_pkg::FRAME_MARKER, int'(vlcp_pkg::MARKER_LEN), filled, w);
      if (filled) begin
        r.word          = w;
        r.last_of_frame = (pend_fill == 0);
        expected_words.push_back(r);
      end
      // flush the zero-padded tail, then reopen the frame
      if (pend_fill != 0) begin
        r.word          = pend_word;
        r.last_of_frame = 1'b1;
        expected_words.push_back(r);
      end
      pend_word = vlcp_pkg::START_WORD;
      pend_fill = int'(vlcp_pkg::START_FILL);
    end
  endtask

  always @(posedge clk) begin
    vlcp_pkg::out_item_t exp_word;
    if (!rst_n) begin
      pend_word = vlcp_pkg::START_WORD;
      pend_fill = int'(vlcp_pkg::START_FILL);
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) predict_words(in_data);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word %h (last_of_frame %b)", out_data.word,
                 out_data.last_of_frame);
          fail_count++;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_data.word !== exp_word.word) begin
            $error("word: expected %h, actual %h", exp_word.word, out_data.word);
            fail_count++;
          end
          if (out_data.last_of_frame !== exp_word.last_of_frame) begin
            $error("last_of_frame: expected %b, actual %b", exp_word.last_of_frame,
                   out_data.last_of_frame);
            fail_count++;
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

`default_nettype wire

FILE: tb/variable_length_code_packer_top_test.sv
// Stimulus, clock, output stalls and verdict for the code packer.
`default_nettype none

module variable_length_code_packer_top_test;

  localparam int RANDOM_CODES = 1800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CODE_W       = vlcp_pkg::MAX_CODE_BITS;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  vlcp_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  vlcp_pkg::out_item_t out_data;
  int                  fail_count;
  int                  words_pending;
  int                  idle_cycles = 0;
  int                  burst_left  = 0;

  variable_length_code_packer_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  vlcp_word_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic vlcp_pkg::in_item_t make_item(input logic mode,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic two_min);
    vlcp_pkg::in_item_t it;
    it.mode        = mode;
    it.code        = code;
    it.two_bit_min = two_min;
    return it;
  endfunction

  // Offer one word in bursts; drop valid for a random gap between some bursts.
  task automatic send_word(input vlcp_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : receiver
    int mode_sel;
    int span;
    wait (rst_n);
    @(posedge clk);
    repeat (150) begin
      out_stall <= ($urandom_range(0, 3) == 0);
      @(posedge clk);
    end
    // long hold-off so the queue fills and the input backs up
    out_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      mode_sel = $urandom_range(0, 4);
      span     = $urandom_range(32, 128);
      for (int c = 0; c < span; c++) begin
        case (mode_sel)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          3: out_stall <= (c % 3 == 0);
          default: out_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                 len;
    logic [CODE_W-1:0]  code;
    vlcp_pkg::in_item_t item;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // finish right after reset: markers fill exactly one word
    send_word(make_item(vlcp_pkg::MODE_FINISH, 16'h0000, 1'b0));
    // append that exactly completes a word, then finish from empty
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'hFFFF, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_FINISH, 16'hFFFF, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0000, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0000, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0001, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0001, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0002, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0003, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h8000, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h7FFF, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'hAAAA, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h5555, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'hFFFF, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_FINISH, 16'h5A5A, 1'b1));
    // finish that spills past a word: two words out
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h000F, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_FINISH, 16'hA5A5, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_APPEND, 16'h0000, 1'b1));
    send_word(make_item(vlcp_pkg::MODE_FINISH, 16'h0000, 1'b0));
    send_word(make_item(vlcp_pkg::MODE_FINISH, 16'hFFFF, 1'b0));

    for (int n = 0; n < RANDOM_CODES; n++) begin
      if ($urandom_range(0, 39) == 0) begin
        item = make_item(vlcp_pkg::MODE_FINISH, CODE_W'($urandom),
                         1'($urandom_range(0, 1)));
      end else begin
        len  = int'($urandom_range(1, CODE_W));
        code = CODE_W'($urandom & ((32'd1 << len) - 32'd1));
        if ($urandom_range(0, 7) == 0) code = CODE_W'($urandom);
        item = make_item(vlcp_pkg::MODE_APPEND, code, 1'($urandom_range(0, 1)));
      end
      send_word(item);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
src/vlcp_pkg.sv
src/vlcp_front.sv
src/vlcp_queue.sv
src/vlcp_back.sv
src/variable_length_code_packer_top.sv
tb/vlcp_word_checker.sv
tb/variable_length_code_packer_top_test.sv
